>>> rtl/bedpt_pkg.sv
// ----------------------------------------------------------------------------
// Button tracker package
// Shared constants, codes and types of the button edge and double press
// tracker.
// ----------------------------------------------------------------------------
package bedpt_pkg;

    localparam int NUM_KEYS_DEF = 32;

    localparam int KEY_W   = 5;
    localparam int TIME_W  = 32;
    localparam int DELTA_W = 16;
    localparam int AXIS_W  = 16;
    localparam int HELD_W  = 16;
    localparam int WIN_W   = 16;
    localparam int MARG_W  = 15;
    localparam int CMD_W   = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd1;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = 16'd250;
    localparam logic [MARG_W-1:0] MARGIN_RESET = 15'd14746;
    localparam logic [AXIS_W-1:0] AXIS_FULL    = 16'h7FFF;
    localparam logic [HELD_W-1:0] HELD_MAX     = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_PRESS   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_AXIS    = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctrl;

endpackage

>>> rtl/button_edge_double_press_tracker.sv
// ----------------------------------------------------------------------------
// Button edge and double press tracker
// Tracks per-key press, release, double press, held time and axis level.
//
// Channel   Handshake              Payload
// command   start / busy           i_cmd, i_key_index, i_tick_delta,
//                                  i_axis_value
// result    o_done (one cycle)     o_key_pressed, o_key_released, o_key_held,
//                                  o_key_double_pressed, o_key_axis,
//                                  o_key_held_time
// config    i_cfg_valid / ready    i_cfg_index, i_cfg_data
//
// A transaction reads the press time and axis RAM (registered read) as the
// command is captured, then updates the key and loads the result register.
// The result strobe follows in the next cycle, while a new command is taken.
// Reset is synchronous and clears all key state at once, RAM via valid bits.
// The receiver cannot stall results; the config port is always ready.
// ----------------------------------------------------------------------------
module button_edge_double_press_tracker import bedpt_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [KEY_W-1:0]         i_key_index,
    input  logic [DELTA_W-1:0]       i_tick_delta,
    input  logic signed [AXIS_W-1:0] i_axis_value,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    output logic                     o_done,
    output logic                     o_key_pressed,
    output logic                     o_key_released,
    output logic                     o_key_held,
    output logic                     o_key_double_pressed,
    output logic signed [AXIS_W-1:0] o_key_axis,
    output logic [HELD_W-1:0]        o_key_held_time
);

    t_ctrl ctrl;

    assign o_cfg_ready = 1'b1;

    bedpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_ctrl  (ctrl)
    );

    bedpt_dp #(
        .NUM_KEYS (NUM_KEYS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctrl               (ctrl),
        .i_cmd                (i_cmd),
        .i_key_index          (i_key_index),
        .i_tick_delta         (i_tick_delta),
        .i_axis_value         (i_axis_value),
        .i_cfg_we             (i_cfg_valid && o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_key_pressed        (o_key_pressed),
        .o_key_released       (o_key_released),
        .o_key_held           (o_key_held),
        .o_key_double_pressed (o_key_double_pressed),
        .o_key_axis           (o_key_axis),
        .o_key_held_time      (o_key_held_time)
    );

endmodule

>>> rtl/bedpt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module bedpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bedpt_ctrl.sv
// ----------------------------------------------------------------------------
// Button tracker controller
// Sequences capture and execution of one transaction and marks its result.
// ----------------------------------------------------------------------------
module bedpt_ctrl import bedpt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    output logic  o_done,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_EXEC);
        end
    end

    always_comb begin
        n_state        = r_state;
        o_busy         = 1'b0;
        o_ctrl.capture = 1'b0;
        o_ctrl.exec    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_busy      = 1'b1;
                o_ctrl.exec = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

>>> rtl/bedpt_dp.sv
// ----------------------------------------------------------------------------
// Button tracker datapath
// Per-key flag and held time registers, press time and axis RAM, the time
// counter, configuration registers and the result register.
// ----------------------------------------------------------------------------
module bedpt_dp import bedpt_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl                   i_ctrl,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [KEY_W-1:0]        i_key_index,
    input  logic [DELTA_W-1:0]      i_tick_delta,
    input  logic signed [AXIS_W-1:0] i_axis_value,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output logic                    o_key_pressed,
    output logic                    o_key_released,
    output logic                    o_key_held,
    output logic                    o_key_double_pressed,
    output logic signed [AXIS_W-1:0] o_key_axis,
    output logic [HELD_W-1:0]       o_key_held_time
);

    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int RW = TIME_W + AXIS_W;

    t_cmd                r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [DELTA_W-1:0]  r_dt;
    logic [AXIS_W-1:0]   r_val;
    logic [WIN_W-1:0]    r_window;
    logic [MARG_W-1:0]   r_margin;
    logic [TIME_W-1:0]   r_now;

    logic [NUM_KEYS-1:0] r_down;
    logic [NUM_KEYS-1:0] r_pressed;
    logic [NUM_KEYS-1:0] r_released;
    logic [NUM_KEYS-1:0] r_double;
    logic [NUM_KEYS-1:0] r_ram_vld;
    logic [HELD_W-1:0]   r_held [NUM_KEYS];

    logic                r_res_pressed;
    logic                r_res_released;
    logic                r_res_held;
    logic                r_res_double;
    logic [AXIS_W-1:0]   r_res_axis;
    logic [HELD_W-1:0]   r_res_held_time;

    logic [HELD_W:0]     tick_sum  [NUM_KEYS];
    logic [HELD_W-1:0]   tick_held [NUM_KEYS];

    logic [AW-1:0]       addr;
    logic                k_ok;
    logic [RW-1:0]       ram_rdata;
    logic                ram_we;
    logic [TIME_W-1:0]   cur_last;
    logic [AXIS_W-1:0]   cur_axis;
    logic                cur_down;
    logic [AXIS_W-1:0]   new_mag;
    logic [AXIS_W-1:0]   old_mag;
    logic [AXIS_W-1:0]   margin_x;
    logic                now_over;
    logic                was_over;
    logic                do_press;
    logic                do_rel;
    logic [TIME_W-1:0]   elapsed;
    logic                dbl;
    logic                k_down;
    logic                k_pr;
    logic                k_rl;
    logic                k_db;
    logic [TIME_W-1:0]   k_last;
    logic [AXIS_W-1:0]   k_axis;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd <= t_cmd'(i_cmd);
            r_key <= i_key_index;
            r_dt  <= i_tick_delta;
            r_val <= i_axis_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW: r_window <= i_cfg_data;
                CFG_MARGIN: r_margin <= i_cfg_data[MARG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign addr   = AW'(r_key);
    assign k_ok   = (int'(r_key) < NUM_KEYS);
    assign ram_we = i_ctrl.exec && k_ok && (r_cmd != CMD_TICK);

    bedpt_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_KEYS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata ({k_last, k_axis}),
        .i_raddr (AW'(i_key_index)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int i = 0; i < NUM_KEYS; i++) begin
            tick_sum[i] = {1'b0, r_held[i]} + {1'b0, r_dt};
            if (!r_down[i]) begin
                tick_held[i] = '0;
            end else if (tick_sum[i][HELD_W]) begin
                tick_held[i] = HELD_MAX;
            end else begin
                tick_held[i] = tick_sum[i][HELD_W-1:0];
            end
        end
    end

    always_comb begin
        cur_down = r_down[addr];
        cur_last = r_ram_vld[addr] ? ram_rdata[RW-1:AXIS_W] : '0;
        cur_axis = r_ram_vld[addr] ? ram_rdata[AXIS_W-1:0] : '0;
        new_mag  = r_val[AXIS_W-1] ? (~r_val + 16'd1) : r_val;
        old_mag  = cur_axis[AXIS_W-1] ? (~cur_axis + 16'd1) : cur_axis;
        margin_x = {1'b0, r_margin};
        now_over = (new_mag >= margin_x);
        was_over = (old_mag >= margin_x);
        do_press = (r_cmd == CMD_PRESS) || ((r_cmd == CMD_AXIS) && now_over && !was_over);
        do_rel   = (r_cmd == CMD_RELEASE) || ((r_cmd == CMD_AXIS) && !now_over && was_over);
        elapsed  = r_now - cur_last;
        dbl      = (elapsed < {16'd0, r_window});

        k_down = cur_down;
        k_pr   = r_pressed[addr];
        k_rl   = r_released[addr];
        k_db   = r_double[addr];
        k_last = cur_last;
        k_axis = cur_axis;
        if (do_press) begin
            if (!cur_down) begin
                k_pr   = 1'b1;
                k_db   = dbl;
                k_last = r_now;
                k_axis = AXIS_FULL;
            end
            k_down = 1'b1;
        end else if (do_rel) begin
            k_down = 1'b0;
            k_rl   = 1'b1;
            k_axis = '0;
        end
        if (r_cmd == CMD_AXIS) begin
            k_axis = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now      <= '0;
            r_down     <= '0;
            r_pressed  <= '0;
            r_released <= '0;
            r_double   <= '0;
            r_ram_vld  <= '0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_held[i] <= '0;
            end
        end else if (i_ctrl.exec) begin
            if (r_cmd == CMD_TICK) begin
                r_now      <= r_now + TIME_W'(r_dt);
                r_pressed  <= '0;
                r_released <= '0;
                r_double   <= '0;
                for (int i = 0; i < NUM_KEYS; i++) begin
                    r_held[i] <= tick_held[i];
                end
            end else if (k_ok) begin
                r_down[addr]     <= k_down;
                r_pressed[addr]  <= k_pr;
                r_released[addr] <= k_rl;
                r_double[addr]   <= k_db;
                r_ram_vld[addr]  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            if (!k_ok) begin
                r_res_pressed   <= 1'b0;
                r_res_released  <= 1'b0;
                r_res_held      <= 1'b0;
                r_res_double    <= 1'b0;
                r_res_axis      <= '0;
                r_res_held_time <= '0;
            end else if (r_cmd == CMD_TICK) begin
                r_res_pressed   <= 1'b0;
                r_res_released  <= 1'b0;
                r_res_held      <= cur_down;
                r_res_double    <= 1'b0;
                r_res_axis      <= cur_axis;
                r_res_held_time <= tick_held[addr];
            end else begin
                r_res_pressed   <= k_pr;
                r_res_released  <= k_rl;
                r_res_held      <= k_down;
                r_res_double    <= k_db;
                r_res_axis      <= k_axis;
                r_res_held_time <= r_held[addr];
            end
        end
    end

    assign o_key_pressed        = r_res_pressed;
    assign o_key_released       = r_res_released;
    assign o_key_held           = r_res_held;
    assign o_key_double_pressed = r_res_double;
    assign o_key_axis           = r_res_axis;
    assign o_key_held_time      = r_res_held_time;

endmodule

>>> rtl/bedpt_checker.sv
// ----------------------------------------------------------------------------
// Button tracker checker
// Port-level timing checks of the command and result channels.
// ----------------------------------------------------------------------------
module bedpt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted transaction did not raise busy.");

    a_busy_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (!busy && o_done))
        else $error("Busy did not end with a result strobe.");

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("Result strobe without a finished transaction.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_done))
        else $error("Block not idle after reset.");

endmodule

bind button_edge_double_press_tracker bedpt_checker u_bedpt_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button edge and double press tracker testbench
// A clocked driver sends key commands from a queue that the stimulus process
// fills: a directed set of corner cases, a double press sequence around a
// long tick, and random phases of taps, axis sweeps, ticks and noise under
// several register settings and idle patterns. A key state predictor computes
// every result on acceptance. The monitor compares each strobed result field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import bedpt_pkg::*;

    localparam int CYCLE_LIMIT   = 1_200_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int BURST_ITEMS   = 150;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        t_cmd                     cmd;
        logic [KEY_W-1:0]         key;
        logic [DELTA_W-1:0]       delta;
        logic signed [AXIS_W-1:0] axis;
    } t_key_cmd;

    typedef struct {
        logic                     pressed;
        logic                     released;
        logic                     held;
        logic                     dbl;
        logic signed [AXIS_W-1:0] axis;
        logic [HELD_W-1:0]        held_time;
    } t_key_status;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [CMD_W-1:0]         i_cmd = '0;
    logic [KEY_W-1:0]         i_key_index = '0;
    logic [DELTA_W-1:0]       i_tick_delta = '0;
    logic signed [AXIS_W-1:0] i_axis_value = '0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     o_done;
    logic                     o_key_pressed;
    logic                     o_key_released;
    logic                     o_key_held;
    logic                     o_key_double_pressed;
    logic signed [AXIS_W-1:0] o_key_axis;
    logic [HELD_W-1:0]        o_key_held_time;

    button_edge_double_press_tracker DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_cmd                (i_cmd),
        .i_key_index          (i_key_index),
        .i_tick_delta         (i_tick_delta),
        .i_axis_value         (i_axis_value),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_done               (o_done),
        .o_key_pressed        (o_key_pressed),
        .o_key_released       (o_key_released),
        .o_key_held           (o_key_held),
        .o_key_double_pressed (o_key_double_pressed),
        .o_key_axis           (o_key_axis),
        .o_key_held_time      (o_key_held_time)
    );

    always #10 i_clk = ~i_clk;

    t_key_cmd    key_cmd_q[$];
    t_key_status key_status_q[$];
    t_key_cmd    cmd_on_port;
    int          idle_pct = 0;
    int          fail_cnt = 0;
    int          cycle_cnt = 0;

    // Predicted key state and register copies.
    logic [WIN_W-1:0]         cfg_window = WINDOW_RESET;
    logic [MARG_W-1:0]        cfg_margin = MARGIN_RESET;
    logic [TIME_W-1:0]        now_ms = '0;
    logic                     key_down  [NUM_KEYS_DEF];
    logic                     key_edge  [NUM_KEYS_DEF];
    logic                     key_rel   [NUM_KEYS_DEF];
    logic                     key_dbl   [NUM_KEYS_DEF];
    logic [HELD_W-1:0]        key_held  [NUM_KEYS_DEF];
    logic [TIME_W-1:0]        last_press[NUM_KEYS_DEF];
    logic signed [AXIS_W-1:0] key_axis  [NUM_KEYS_DEF];

    initial begin
        for (int i = 0; i < NUM_KEYS_DEF; i++) begin
            key_down[i]   = 1'b0;
            key_edge[i]   = 1'b0;
            key_rel[i]    = 1'b0;
            key_dbl[i]    = 1'b0;
            key_held[i]   = '0;
            last_press[i] = '0;
            key_axis[i]   = '0;
        end
    end

    function automatic logic [AXIS_W:0] axis_mag(input logic signed [AXIS_W-1:0] v);
        logic [AXIS_W:0] wide;
        wide = {v[AXIS_W-1], v};
        return v[AXIS_W-1] ? ((AXIS_W+1)'(0) - wide) : wide;
    endfunction

    function automatic void key_press(input int k);
        logic [TIME_W-1:0] gap;
        if (!key_down[k]) begin
            gap           = now_ms - last_press[k];
            key_edge[k]   = 1'b1;
            key_dbl[k]    = (gap < cfg_window);
            last_press[k] = now_ms;
            key_axis[k]   = AXIS_FULL;
        end
        key_down[k] = 1'b1;
    endfunction

    function automatic void key_release(input int k);
        key_down[k] = 1'b0;
        key_rel[k]  = 1'b1;
        key_axis[k] = '0;
    endfunction

    function automatic t_key_status track_key_event(input t_key_cmd c);
        t_key_status r;
        logic [HELD_W:0] sum;
        logic now_over;
        logic was_over;
        int k;
        k = c.key;
        case (c.cmd)
            CMD_TICK: begin
                now_ms = now_ms + c.delta;
                for (int i = 0; i < NUM_KEYS_DEF; i++) begin
                    key_edge[i] = 1'b0;
                    key_rel[i]  = 1'b0;
                    key_dbl[i]  = 1'b0;
                    if (key_down[i]) begin
                        sum = {1'b0, key_held[i]} + {1'b0, c.delta};
                        key_held[i] = sum[HELD_W] ? HELD_MAX : sum[HELD_W-1:0];
                    end else begin
                        key_held[i] = '0;
                    end
                end
            end
            CMD_PRESS: key_press(k);
            CMD_RELEASE: key_release(k);
            default: begin
                now_over = axis_mag(c.axis) >= cfg_margin;
                was_over = axis_mag(key_axis[k]) >= cfg_margin;
                if (now_over && !was_over) key_press(k);
                else if (!now_over && was_over) key_release(k);
                key_axis[k] = c.axis;
            end
        endcase
        r.pressed   = key_edge[k];
        r.released  = key_rel[k];
        r.held      = key_down[k];
        r.dbl       = key_dbl[k];
        r.axis      = key_axis[k];
        r.held_time = key_held[k];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_key_cmd nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) key_status_q.push_back(track_key_event(cmd_on_port));
            if (!start || !busy) begin
                if (key_cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = key_cmd_q.pop_front();
                    cmd_on_port  <= nxt;
                    start        <= 1'b1;
                    i_cmd        <= nxt.cmd;
                    i_key_index  <= nxt.key;
                    i_tick_delta <= nxt.delta;
                    i_axis_value <= nxt.axis;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_key_status want;
        if (i_rst_n && o_done) begin
            if (key_status_q.size() == 0) begin
                $display("%0t: result with no transaction pending, expected none, actual axis %0d",
                         $time, o_key_axis);
                fail_cnt++;
            end else begin
                want = key_status_q.pop_front();
                if (want.pressed !== o_key_pressed)
                    report("key_pressed", want.pressed, o_key_pressed);
                if (want.released !== o_key_released)
                    report("key_released", want.released, o_key_released);
                if (want.held !== o_key_held)
                    report("key_held", want.held, o_key_held);
                if (want.dbl !== o_key_double_pressed)
                    report("key_double_pressed", want.dbl, o_key_double_pressed);
                if (want.axis !== o_key_axis)
                    report("key_axis", want.axis, o_key_axis);
                if (want.held_time !== o_key_held_time)
                    report("key_held_time", want.held_time, o_key_held_time);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic put_cmd(input t_cmd c, input int k, input int d, input int a);
        t_key_cmd item;
        item.cmd   = c;
        item.key   = k[KEY_W-1:0];
        item.delta = d[DELTA_W-1:0];
        item.axis  = a[AXIS_W-1:0];
        key_cmd_q.push_back(item);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (key_cmd_q.size() != 0 || start || key_status_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WINDOW) cfg_window = val[WIN_W-1:0];
        else if (idx == CFG_MARGIN) cfg_margin = val[MARG_W-1:0];
    endtask

    task automatic add_random(input int n);
        int added;
        int kind;
        int k;
        int lim;
        int j;
        int mv;
        int a;
        added = 0;
        while (added < n) begin
            kind = $urandom_range(0, 9);
            k    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
            lim  = int'(cfg_window) + 8;
            if (lim > 65535) lim = 65535;
            if (kind < 4) begin
                put_cmd(CMD_PRESS, k, $urandom, $urandom);
                put_cmd(CMD_TICK, $urandom_range(0, 31), $urandom_range(0, lim / 2), $urandom);
                put_cmd(CMD_RELEASE, k, $urandom, $urandom);
                put_cmd(CMD_TICK, $urandom_range(0, 31), $urandom_range(0, lim / 2), $urandom);
                put_cmd(CMD_PRESS, k, $urandom, $urandom);
                added += 5;
            end else if (kind < 7) begin
                repeat (4) begin
                    j  = $urandom_range(0, 4);
                    mv = int'(cfg_margin) + j - 2;
                    if (mv < 0) mv = 0;
                    if ($urandom_range(0, 3) == 0) a = $urandom;
                    else if ($urandom_range(0, 1) == 1) a = (mv > 32768) ? -32768 : -mv;
                    else a = (mv > 32767) ? 32767 : mv;
                    put_cmd(CMD_AXIS, k, $urandom, a);
                end
                added += 4;
            end else if (kind < 8) begin
                put_cmd(CMD_TICK, $urandom_range(0, 31),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 300), $urandom);
                added += 1;
            end else begin
                put_cmd(t_cmd'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom, $urandom);
                added += 1;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of both registers are in force here.
        put_cmd(CMD_PRESS,   0, 'hFFFF, 'h7FFF);
        put_cmd(CMD_PRESS,   0, 0, 0);
        put_cmd(CMD_TICK,    0, 'hFFFF, 'h8000);
        put_cmd(CMD_TICK,    0, 'hFFFF, 0);
        put_cmd(CMD_RELEASE, 0, 'hFFFF, 'hFFFF);
        put_cmd(CMD_TICK,    0, 0, 0);
        put_cmd(CMD_PRESS,  31, 0, 0);
        put_cmd(CMD_TICK,   31, 100, 0);
        put_cmd(CMD_RELEASE, 31, 0, 0);
        put_cmd(CMD_TICK,   31, 100, 0);
        put_cmd(CMD_PRESS,  31, 0, 0);
        put_cmd(CMD_AXIS,    5, 0, -32768);
        put_cmd(CMD_AXIS,    5, 0, 32767);
        put_cmd(CMD_AXIS,    5, 0, 14745);
        put_cmd(CMD_AXIS,    5, 0, 14746);
        put_cmd(CMD_AXIS,    5, 0, -14746);
        put_cmd(CMD_AXIS,    5, 0, -14745);
        put_cmd(CMD_AXIS,    5, 'hFFFF, 0);
        put_cmd(CMD_RELEASE, 7, 0, 0);
        put_cmd(CMD_PRESS,   9, 0, 0);
        put_cmd(CMD_AXIS,    9, 0, 0);
        put_cmd(CMD_PRESS,   2, 0, 0);
        put_cmd(CMD_TICK,   17, 1, 'h5555);
        wait_drained();

        // Press again after a long tick, then twice within the window.
        put_cmd(CMD_TICK,    2, 'hFFFF, 0);
        put_cmd(CMD_RELEASE, 2, 0, 0);
        put_cmd(CMD_PRESS,   2, 0, 0);
        put_cmd(CMD_TICK,    2, 150, 0);
        put_cmd(CMD_RELEASE, 2, 0, 0);
        put_cmd(CMD_PRESS,   2, 0, 0);
        put_cmd(CMD_PRESS,  20, 0, 0);
        wait_drained();

        write_reg(CFG_SPARE_A, 'hFFFF);
        write_reg(CFG_SPARE_B, 'h5A5A);

        write_reg(CFG_WINDOW, 0);
        write_reg(CFG_MARGIN, 0);
        idle_pct = 0;
        add_random(BURST_ITEMS);
        wait_drained();

        write_reg(CFG_WINDOW, 65535);
        write_reg(CFG_MARGIN, 32767);
        idle_pct = 64;
        add_random(BURST_ITEMS);
        wait_drained();

        write_reg(CFG_WINDOW, 1000);
        write_reg(CFG_MARGIN, 8000);
        idle_pct = 0;
        add_random(BURST_ITEMS);
        wait_drained();

        write_reg(CFG_WINDOW, $urandom_range(0, 65535));
        write_reg(CFG_MARGIN, $urandom_range(0, 32767));
        idle_pct = 25;
        add_random(BURST_ITEMS);
        wait_drained();

        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/bedpt_pkg.sv
rtl/bedpt_ram.sv
rtl/bedpt_ctrl.sv
rtl/bedpt_dp.sv
rtl/button_edge_double_press_tracker.sv
rtl/bedpt_checker.sv
tb/tb_top.sv
